// ----- src/ufec_pkg.sv -----
// shared widths, limits and channel payload types for the union-find edge classifier
`timescale 1ns / 1ps

package ufec_pkg;

   // vertex count default
   localparam int VERTICES_DEFAULT = 1024;

   // field widths
   localparam int VERTEX_WIDTH = 10;
   localparam int WEIGHT_WIDTH = 8;
   localparam int SUM_WIDTH    = 24;
   localparam int COUNT_WIDTH  = 16;
   localparam int RANK_WIDTH   = 4;

   // width that holds any vertex count up to the largest allowed
   localparam int LIMIT_WIDTH = 17;

   // saturation limits
   localparam logic [SUM_WIDTH-1:0]   SUM_MAX   = 24'h7FFFFF;
   localparam logic [SUM_WIDTH-1:0]   SUM_MIN   = 24'h800000;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = 16'hFFFF;
   localparam logic [RANK_WIDTH-1:0]  RANK_MAX  = 4'hF;

   // request payload: one edge
   typedef struct packed {
      logic                           restart;
      logic [VERTEX_WIDTH-1:0]        vertex_a;
      logic [VERTEX_WIDTH-1:0]        vertex_b;
      logic signed [WEIGHT_WIDTH-1:0] edge_weight;
   } req_payload_type;

   // response payload: classification and running totals
   typedef struct packed {
      logic                        edge_removed;
      logic signed [SUM_WIDTH-1:0] removed_weight_sum;
      logic [COUNT_WIDTH-1:0]      removed_edge_count;
   } rsp_payload_type;

endpackage

// ----- src/ufec_if.sv -----
// valid/ready channel interfaces for edge requests and classification responses
`timescale 1ns / 1ps

interface ufec_req_if;
   logic                     valid;
   logic                     ready;
   ufec_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface ufec_rsp_if;
   logic                     valid;
   logic                     ready;
   ufec_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ----- src/ufec_ram.sv -----
// generic single-write, single-read synchronous ram with registered read data
`timescale 1ns / 1ps

module ufec_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/union_find_edge_classifier.sv -----
// Union-find edge classifier: the time from request to response grows with La + Lb,
// La and Lb the parent-chain lengths of the two endpoints
// (at most log2 VERTICES each), plus a rank-update state for a merge of equal ranks.
// One request at a time; the next can be taken once the response is registered.
// Throughput is set by the single read port of the node ram walking one link a cycle.
// Reset (synchronous) and every restart request run a clearing pass over all VERTICES nodes.
`timescale 1ns / 1ps

module union_find_edge_classifier #(
   parameter int VERTICES = ufec_pkg::VERTICES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   ufec_req_if.sink    req_ch,
   ufec_rsp_if.source  rsp_ch
);

   localparam int VW = $clog2(VERTICES);
   localparam int RW = ufec_pkg::RANK_WIDTH;
   localparam int NW = VW + RW;
   localparam int SW = ufec_pkg::SUM_WIDTH;
   localparam int CW = ufec_pkg::COUNT_WIDTH;
   localparam int WW = ufec_pkg::WEIGHT_WIDTH;
   localparam int LW = ufec_pkg::LIMIT_WIDTH;
   localparam int XW = ufec_pkg::LIMIT_WIDTH - ufec_pkg::VERTEX_WIDTH;
   localparam logic [LW-1:0] V_LIMIT = LW'(VERTICES);
   localparam logic [VW-1:0] V_LAST  = VW'(VERTICES - 1);

   typedef enum logic [8:0] {
      S_CLEAR    = 9'b000000001,
      S_IDLE     = 9'b000000010,
      S_FIND_RD  = 9'b000000100,
      S_FIND_CHK = 9'b000001000,
      S_COMP_RD  = 9'b000010000,
      S_COMP_CHK = 9'b000100000,
      S_MERGE    = 9'b001000000,
      S_MERGE_EQ = 9'b010000000,
      S_DONE     = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   logic [VW-1:0]        clr_ff, clr_in;
   logic                 restart_ff, restart_in;
   logic                 range_ff, range_in;
   logic [VW-1:0]        vb_ff, vb_in;
   logic signed [WW-1:0] weight_ff, weight_in;
   logic                 side_ff, side_in;
   logic [VW-1:0]        start_ff, start_in;
   logic [VW-1:0]        cur_ff, cur_in;
   logic [VW-1:0]        root_ff, root_in;
   logic [RW-1:0]        rrank_ff, rrank_in;
   logic [VW-1:0]        ra_ff, ra_in;
   logic [RW-1:0]        rka_ff, rka_in;
   logic                 removed_ff, removed_in;
   logic [SW-1:0]        sum_ff, sum_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   ufec_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;

   // node ram port signals
   logic          wr_en;
   logic [VW-1:0] wr_addr;
   logic [NW-1:0] wr_data;
   logic          rd_en;
   logic [VW-1:0] rd_addr;
   logic [NW-1:0] rd_data;
   logic [VW-1:0] rd_parent;
   logic [RW-1:0] rd_rank;

   logic          req_fire;
   logic          in_range;
   logic          find_done;
   logic [SW:0]   sum_wide;
   logic [SW-1:0] sum_sat;

   // parent and rank of every vertex in one ram
   ufec_ram #(
      .WIDTH (NW),
      .DEPTH (VERTICES)
   ) u_node_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_parent = rd_data[VW-1:0];
   assign rd_rank   = rd_data[NW-1:VW];

   // request handshake and endpoint range check
   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign in_range     = ({{XW{1'b0}}, req_ch.payload.vertex_a} < V_LIMIT) &&
                         ({{XW{1'b0}}, req_ch.payload.vertex_b} < V_LIMIT);

   // saturating removed-weight sum
   assign sum_wide = {sum_ff[SW-1], sum_ff} + {{(SW+1-WW){weight_ff[WW-1]}}, weight_ff};
   always_comb begin
      case (sum_wide[SW:SW-1])
         2'b01:   sum_sat = ufec_pkg::SUM_MAX;
         2'b10:   sum_sat = ufec_pkg::SUM_MIN;
         default: sum_sat = sum_wide[SW-1:0];
      endcase
   end

   // response channel
   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_data_ff;

   // sequencer: clear, find with compression for each endpoint, merge, respond
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      restart_in   = restart_ff;
      range_in     = range_ff;
      vb_in        = vb_ff;
      weight_in    = weight_ff;
      side_in      = side_ff;
      start_in     = start_ff;
      cur_in       = cur_ff;
      root_in      = root_ff;
      rrank_in     = rrank_ff;
      ra_in        = ra_ff;
      rka_in       = rka_ff;
      removed_in   = removed_ff;
      sum_in       = sum_ff;
      cnt_in       = cnt_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      wr_en        = 1'b0;
      wr_addr      = cur_ff;
      wr_data      = {rd_rank, root_ff};
      rd_en        = 1'b0;
      rd_addr      = cur_ff;
      find_done    = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = {{RW{1'b0}}, clr_ff};
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == V_LAST) begin
               clr_in = '0;
               if (!restart_ff) begin
                  state_in = S_IDLE;
               end else if (range_ff) begin
                  state_in = S_FIND_RD;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               restart_in = req_ch.payload.restart;
               range_in   = in_range;
               vb_in      = VW'(req_ch.payload.vertex_b);
               weight_in  = req_ch.payload.edge_weight;
               side_in    = 1'b0;
               start_in   = VW'(req_ch.payload.vertex_a);
               cur_in     = VW'(req_ch.payload.vertex_a);
               removed_in = 1'b0;
               if (req_ch.payload.restart) begin
                  sum_in   = '0;
                  cnt_in   = '0;
                  clr_in   = '0;
                  state_in = S_CLEAR;
               end else if (in_range) begin
                  state_in = S_FIND_RD;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_FIND_RD: begin
            rd_en    = 1'b1;
            rd_addr  = cur_ff;
            state_in = S_FIND_CHK;
         end
         S_FIND_CHK: begin
            if (rd_parent == cur_ff) begin
               root_in  = cur_ff;
               rrank_in = rd_rank;
               cur_in   = start_ff;
               state_in = S_COMP_RD;
            end else begin
               cur_in  = rd_parent;
               rd_en   = 1'b1;
               rd_addr = rd_parent;
            end
         end
         S_COMP_RD: begin
            if (cur_ff == root_ff) begin
               find_done = 1'b1;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = cur_ff;
               state_in = S_COMP_CHK;
            end
         end
         S_COMP_CHK: begin
            // point this node at the root, keeping its rank
            wr_en   = 1'b1;
            wr_addr = cur_ff;
            wr_data = {rd_rank, root_ff};
            cur_in  = rd_parent;
            if (rd_parent == root_ff) begin
               find_done = 1'b1;
            end else begin
               rd_en   = 1'b1;
               rd_addr = rd_parent;
            end
         end
         S_MERGE: begin
            if (ra_ff == root_ff) begin
               removed_in = 1'b1;
               state_in   = S_DONE;
            end else if (rka_ff < rrank_ff) begin
               wr_en    = 1'b1;
               wr_addr  = ra_ff;
               wr_data  = {rka_ff, root_ff};
               state_in = S_DONE;
            end else if (rka_ff > rrank_ff) begin
               wr_en    = 1'b1;
               wr_addr  = root_ff;
               wr_data  = {rrank_ff, ra_ff};
               state_in = S_DONE;
            end else begin
               wr_en    = 1'b1;
               wr_addr  = ra_ff;
               wr_data  = {rka_ff, root_ff};
               state_in = S_MERGE_EQ;
            end
         end
         S_MERGE_EQ: begin
            // equal ranks: the surviving root grows by one, saturating
            wr_en   = 1'b1;
            wr_addr = root_ff;
            if (rrank_ff == ufec_pkg::RANK_MAX) begin
               wr_data = {rrank_ff, root_ff};
            end else begin
               wr_data = {RW'(rrank_ff + 1'b1), root_ff};
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.edge_removed = removed_ff;
               if (removed_ff) begin
                  sum_in = sum_sat;
                  if (cnt_ff != ufec_pkg::COUNT_MAX) begin
                     cnt_in = cnt_ff + 1'b1;
                  end
                  rsp_data_in.removed_weight_sum = sum_sat;
                  rsp_data_in.removed_edge_count =
                     (cnt_ff != ufec_pkg::COUNT_MAX) ? CW'(cnt_ff + 1'b1) : cnt_ff;
               end else begin
                  rsp_data_in.removed_weight_sum = sum_ff;
                  rsp_data_in.removed_edge_count = cnt_ff;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // end of one find: move to the second endpoint or to the merge
      if (find_done) begin
         if (!side_ff) begin
            ra_in    = root_ff;
            rka_in   = rrank_ff;
            side_in  = 1'b1;
            start_in = vb_ff;
            cur_in   = vb_ff;
            state_in = S_FIND_RD;
         end else begin
            state_in = S_MERGE;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         restart_ff   <= 1'b0;
         sum_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         restart_ff   <= restart_in;
         sum_ff       <= sum_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      range_ff    <= range_in;
      vb_ff       <= vb_in;
      weight_ff   <= weight_in;
      side_ff     <= side_in;
      start_ff    <= start_in;
      cur_ff      <= cur_in;
      root_ff     <= root_in;
      rrank_ff    <= rrank_in;
      ra_ff       <= ra_in;
      rka_ff      <= rka_in;
      removed_ff  <= removed_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ----- tb/tb.sv -----
// self-checking testbench for the union-find edge classifier
`timescale 1ns / 1ps

module tb;

   localparam int VERTEX_COUNT     = ufec_pkg::VERTICES_DEFAULT;
   localparam int VW               = ufec_pkg::VERTEX_WIDTH;
   localparam int SW               = ufec_pkg::SUM_WIDTH;
   localparam int CW               = ufec_pkg::COUNT_WIDTH;
   localparam int SUM_HI           = 2 ** (SW - 1) - 1;
   localparam int SUM_LO           = -(2 ** (SW - 1));
   localparam int SELF_LOOP_EDGES  = 60;
   localparam int RANDOM_PER_PHASE = 180;

   // one directed row: the edge, and a typed response where it is obvious
   typedef struct {
      ufec_pkg::req_payload_type edge_req;
      bit                        fixed;
      ufec_pkg::rsp_payload_type fixed_rsp;
   } edge_row_type;

   logic clock;
   logic reset = 1'b1;

   ufec_req_if req_ch ();
   ufec_rsp_if rsp_ch ();

   union_find_edge_classifier #(
      .VERTICES (VERTEX_COUNT)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // shadow forest and removed-edge totals
   logic [VW-1:0]                       forest_parent [VERTEX_COUNT];
   logic [ufec_pkg::RANK_WIDTH-1:0]     forest_rank [VERTEX_COUNT];
   logic signed [SW-1:0]                removed_sum;
   logic [CW-1:0]                       removed_count;

   ufec_pkg::rsp_payload_type pending_classifications [$];
   edge_row_type              directed_rows [$];
   int mismatch_count = 0;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;

   // clock generation
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // run limit
   initial begin
      #40_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   // forest back to singletons, totals to zero
   function automatic void clear_forest();
      for (int i = 0; i < VERTEX_COUNT; i++) begin
         forest_parent[i] = i[VW-1:0];
         forest_rank[i]   = '0;
      end
      removed_sum   = '0;
      removed_count = '0;
   endfunction

   // root lookup with full path compression
   function automatic logic [VW-1:0] find_root(input logic [VW-1:0] v);
      logic [VW-1:0] root;
      logic [VW-1:0] up;
      int steps;
      root  = v;
      steps = 0;
      while (forest_parent[root] != root && steps < VERTEX_COUNT) begin
         root = forest_parent[root];
         steps++;
      end
      steps = 0;
      while (v != root && steps < VERTEX_COUNT) begin
         up               = forest_parent[v];
         forest_parent[v] = root;
         v                = up;
         steps++;
      end
      return root;
   endfunction

   // classify one edge and advance the shadow state
   function automatic ufec_pkg::rsp_payload_type classify_edge(
      input ufec_pkg::req_payload_type e);
      ufec_pkg::rsp_payload_type r;
      logic [VW-1:0] ra;
      logic [VW-1:0] rb;
      int s;
      if (e.restart)
         clear_forest();
      r.edge_removed = 1'b0;
      if (int'(e.vertex_a) < VERTEX_COUNT && int'(e.vertex_b) < VERTEX_COUNT) begin
         ra = find_root(e.vertex_a);
         rb = find_root(e.vertex_b);
         if (ra != rb) begin
            // union by rank
            if (forest_rank[ra] < forest_rank[rb]) begin
               forest_parent[ra] = rb;
            end else if (forest_rank[ra] > forest_rank[rb]) begin
               forest_parent[rb] = ra;
            end else begin
               forest_parent[ra] = rb;
               if (forest_rank[rb] != ufec_pkg::RANK_MAX)
                  forest_rank[rb] = forest_rank[rb] + 1'b1;
            end
         end else begin
            // cycle edge: saturating totals
            s = int'(removed_sum) + int'($signed(e.edge_weight));
            if (s > SUM_HI) s = SUM_HI;
            if (s < SUM_LO) s = SUM_LO;
            removed_sum = s[SW-1:0];
            if (removed_count != ufec_pkg::COUNT_MAX)
               removed_count = removed_count + 1'b1;
            r.edge_removed = 1'b1;
         end
      end
      r.removed_weight_sum = removed_sum;
      r.removed_edge_count = removed_count;
      return r;
   endfunction

   function automatic ufec_pkg::req_payload_type make_edge(input bit rs, input int a,
                                                           input int b, input int w);
      ufec_pkg::req_payload_type e;
      e.restart     = rs;
      e.vertex_a    = a[VW-1:0];
      e.vertex_b    = b[VW-1:0];
      e.edge_weight = w[ufec_pkg::WEIGHT_WIDTH-1:0];
      return e;
   endfunction

   function automatic edge_row_type make_row(input bit rs, input int a, input int b,
                                             input int w, input bit fx, input bit rm,
                                             input int sm, input int ct);
      edge_row_type row;
      row.edge_req                     = make_edge(rs, a, b, w);
      row.fixed                        = fx;
      row.fixed_rsp.edge_removed       = rm;
      row.fixed_rsp.removed_weight_sum = sm[SW-1:0];
      row.fixed_rsp.removed_edge_count = ct[CW-1:0];
      return row;
   endfunction

   // append one row to the directed table
   function automatic void add_row(input edge_row_type row);
      directed_rows.insert(directed_rows.size(), row);
   endfunction

   // present one request, wait for acceptance, queue its expected response
   task automatic send_edge(input ufec_pkg::req_payload_type e, input bit fixed,
                            input ufec_pkg::rsp_payload_type fixed_rsp);
      ufec_pkg::rsp_payload_type predicted;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.payload <= e;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      predicted = classify_edge(e);
      pending_classifications.insert(pending_classifications.size(),
                                     fixed ? fixed_rsp : predicted);
   endtask

   // mixed stimulus: clustered windows so sets grow and cycles appear
   task automatic run_random_phase(input int n_items, input int idle, input int stall);
      int window_base;
      int window_span;
      int window_left;
      int roll;
      int a;
      int b;
      int w;
      bit rs;
      send_idle_pct  = idle;
      recv_stall_pct = stall;
      window_left    = 0;
      window_base    = 0;
      window_span    = 2;
      for (int k = 0; k < n_items; k++) begin
         if (window_left == 0) begin
            window_base = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 1023)
                                                       : $urandom_range(0, 127);
            window_span = 2 << $urandom_range(0, 5);
            window_left = $urandom_range(8, 40);
         end
         window_left--;
         roll = $urandom_range(0, 99);
         rs   = ($urandom_range(0, 39) == 0);
         if (roll < 10) begin
            // noise: endpoints anywhere
            a = $urandom_range(0, 1023);
            b = $urandom_range(0, 1023);
         end else if (roll < 15) begin
            // self loop
            a = (window_base + $urandom_range(0, window_span - 1)) % VERTEX_COUNT;
            b = a;
         end else begin
            a = (window_base + $urandom_range(0, window_span - 1)) % VERTEX_COUNT;
            b = (window_base + $urandom_range(0, window_span - 1)) % VERTEX_COUNT;
         end
         if ($urandom_range(0, 3) == 0)
            w = $urandom_range(0, 255);
         else
            w = $urandom_range(0, 200) - 100;
         send_edge(make_edge(rs, a, b, w), 1'b0, '0);
      end
   endtask

   // response checker and receiver stalls
   initial begin
      ufec_pkg::rsp_payload_type want;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_classifications.size() == 0) begin
               mismatch_count++;
               $display("%0t: response with none expected, actual removed=%0d sum=%0d count=%0d",
                        $time, rsp_ch.payload.edge_removed,
                        int'(rsp_ch.payload.removed_weight_sum),
                        rsp_ch.payload.removed_edge_count);
            end else begin
               want = pending_classifications.pop_front();
               if (rsp_ch.payload.edge_removed !== want.edge_removed) begin
                  mismatch_count++;
                  $display("%0t: edge_removed expected %0d actual %0d", $time,
                           want.edge_removed, rsp_ch.payload.edge_removed);
               end
               if (rsp_ch.payload.removed_weight_sum !== want.removed_weight_sum) begin
                  mismatch_count++;
                  $display("%0t: removed_weight_sum expected %0d actual %0d", $time,
                           int'(want.removed_weight_sum),
                           int'(rsp_ch.payload.removed_weight_sum));
               end
               if (rsp_ch.payload.removed_edge_count !== want.removed_edge_count) begin
                  mismatch_count++;
                  $display("%0t: removed_edge_count expected %0d actual %0d", $time,
                           want.removed_edge_count, rsp_ch.payload.removed_edge_count);
               end
            end
         end
         rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // stimulus sequence
   initial begin
      req_ch.valid   <= 1'b0;
      req_ch.payload <= '0;
      clear_forest();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // fresh forest, extremes, self loops, restart
      add_row(make_row(0, 0, 1, 100, 1, 0, 0, 0));
      add_row(make_row(0, 1, 0, -100, 1, 1, -100, 1));
      add_row(make_row(0, 1023, 1023, 127, 1, 1, 27, 2));
      add_row(make_row(0, 1023, 0, -128, 1, 0, 27, 2));
      add_row(make_row(0, 0, 1023, 0, 1, 1, 27, 3));
      add_row(make_row(1, 1023, 1023, -1, 1, 1, -1, 1));
      add_row(make_row(1, 0, 1, 5, 1, 0, 0, 0));
      // rank growth and deeper trees, then cycle edges across them
      add_row(make_row(0, 2, 3, 90, 0, 0, 0, 0));
      add_row(make_row(0, 4, 5, 80, 0, 0, 0, 0));
      add_row(make_row(0, 2, 4, 70, 0, 0, 0, 0));
      add_row(make_row(0, 6, 7, 60, 0, 0, 0, 0));
      add_row(make_row(0, 8, 9, 50, 0, 0, 0, 0));
      add_row(make_row(0, 6, 8, 40, 0, 0, 0, 0));
      add_row(make_row(0, 3, 9, 30, 0, 0, 0, 0));
      add_row(make_row(0, 5, 7, 20, 0, 0, 0, 0));
      add_row(make_row(0, 0, 9, 10, 0, 0, 0, 0));
      add_row(make_row(0, 1, 8, -10, 0, 0, 0, 0));
      // alternating bit patterns on endpoints and weight
      add_row(make_row(0, 'h155, 'h2AA, 'h55, 0, 0, 0, 0));
      add_row(make_row(0, 'h2AA, 'h155, 'hAA, 0, 0, 0, 0));
      add_row(make_row(0, 'h2AA, 9, -128, 0, 0, 0, 0));
      add_row(make_row(0, 'h155, 2, 127, 0, 0, 0, 0));

      foreach (directed_rows[i])
         send_edge(directed_rows[i].edge_req, directed_rows[i].fixed,
                   directed_rows[i].fixed_rsp);

      // run of self loops at the largest weight
      send_edge(make_edge(1, 0, 0, 127), 1'b0, '0);
      for (int k = 0; k < SELF_LOOP_EDGES; k++) begin
         int v;
         v = $urandom_range(0, 1023);
         send_edge(make_edge(0, v, v, 127), 1'b0, '0);
      end

      // random edges under each idling mix
      run_random_phase(RANDOM_PER_PHASE, 0, 0);
      run_random_phase(RANDOM_PER_PHASE, 63, 0);
      run_random_phase(RANDOM_PER_PHASE, 0, 63);
      run_random_phase(RANDOM_PER_PHASE, 34, 34);
      req_ch.valid <= 1'b0;

      // drain outstanding responses
      while (pending_classifications.size() != 0)
         @(posedge clock);
      repeat (64) @(posedge clock);
      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
